[hdl/stvis_pkg.sv]
// shared types and constants of the sorted table value index search
package stvis_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 128;
   localparam int LINEAR_LIMIT        = 5;

   localparam int VALUE_W     = 32;
   localparam int POS_W       = 7;
   localparam int MODE_W      = 2;
   localparam int COUNT_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [MODE_W-1:0] MODE_OFFSET = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ASCEND = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] REG_RANGE_MODE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ITEM_COUNT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INVALID_MARKER = 2'd2;

   localparam logic signed [VALUE_W-1:0] INVALID_MARKER_RESET = 32'sh8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OFFSET,
      ST_LINEAR,
      ST_BINARY,
      ST_FINISH
   } state_type;

endpackage

[hdl/stvis_req_if.sv]
// request channel: table writes and search values
interface stvis_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  operation;
   logic [stvis_pkg::POS_W-1:0]           entry_index;
   logic signed [stvis_pkg::VALUE_W-1:0]  item_value;

   modport source (output valid, output operation, output entry_index, output item_value,
                   input ready);
   modport sink   (input valid, input operation, input entry_index, input item_value,
                   output ready);
endinterface

[hdl/stvis_rsp_if.sv]
// response channel: search results
interface stvis_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [stvis_pkg::POS_W-1:0]  match_index;

   modport source (output valid, output found, output match_index, input ready);
   modport sink   (input valid, input found, input match_index, output ready);
endinterface

[hdl/sorted_table_value_index_search_top.sv]
// sorted table value index search: table memory, search sequencer and response register
//
// A write beat stores one entry and gives no response. A search beat is accepted in the
// idle state, reads the table one entry per step and loads the response in the finish
// state, which waits while an earlier response is not yet taken. An invalid marker or an empty
// table goes straight to finish; contiguous mode makes one read, a linear search over fewer
// than five entries at most count reads, and a binary search at most ceil(log2(count + 1))
// reads. The pace is set by the single read port of the table memory, which delivers one
// entry per cycle. One item is in work at a time; a finished response waits in the output
// register while the next beat is taken. The table needs no clearing after reset.
module sorted_table_value_index_search_top #(
   parameter int TABLE_DEPTH = stvis_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   stvis_req_if.sink                             req_bus,
   stvis_rsp_if.source                           rsp_bus,
   input  logic                                  csr_we,
   input  logic [stvis_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [stvis_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = ($clog2(TABLE_DEPTH + 1) > stvis_pkg::COUNT_W) ?
                       $clog2(TABLE_DEPTH + 1) : stvis_pkg::COUNT_W;
   localparam int SW = CW + 1;
   localparam int VW = stvis_pkg::VALUE_W;
   localparam int PW = stvis_pkg::POS_W;

   // configuration
   logic [stvis_pkg::MODE_W-1:0]   range_mode_ff;
   logic [stvis_pkg::COUNT_W-1:0]  item_count_ff;
   logic signed [VW-1:0]           invalid_marker_ff;

   // sequencer
   stvis_pkg::state_type  state_ff, state_in;
   logic signed [VW-1:0]  key_ff, key_in;
   logic                  asc_ff, asc_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic signed [SW-1:0]  first_ff, first_in;
   logic signed [SW-1:0]  last_ff, last_in;
   logic [AW-1:0]         mid_ff, mid_in;
   logic                  res_found_ff, res_found_in;
   logic [PW-1:0]         res_index_ff, res_index_in;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [PW-1:0]         rsp_index_ff;
   logic                  rsp_load;

   // table memory
   logic signed [VW-1:0]  mem [TABLE_DEPTH];
   logic signed [VW-1:0]  rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;

   logic [CW-1:0]         used_cnt;
   logic                  pos_ok;
   logic signed [VW:0]    diff;
   logic signed [SW-1:0]  mid_s;
   logic signed [SW-1:0]  nfirst;
   logic signed [SW-1:0]  nlast;
   logic [SW:0]           nsum;
   logic                  go_left;

   assign used_cnt = (CW'(item_count_ff) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                             : CW'(item_count_ff);
   assign pos_ok   = CW'(req_bus.entry_index) < CW'(TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         range_mode_ff     <= stvis_pkg::MODE_OFFSET;
         item_count_ff     <= '0;
         invalid_marker_ff <= stvis_pkg::INVALID_MARKER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            stvis_pkg::REG_RANGE_MODE:     range_mode_ff     <= csr_wdata[stvis_pkg::MODE_W-1:0];
            stvis_pkg::REG_ITEM_COUNT:     item_count_ff     <= csr_wdata[stvis_pkg::COUNT_W-1:0];
            stvis_pkg::REG_INVALID_MARKER: invalid_marker_ff <= signed'(csr_wdata[VW-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_bus.entry_index)] <= req_bus.item_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      asc_in       = asc_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      mid_in       = mid_ff;
      res_found_in = res_found_ff;
      res_index_in = res_index_ff;
      rd_addr      = mid_ff;
      wr_en        = 1'b0;
      rsp_load     = 1'b0;

      diff    = {rd_data_ff[VW-1], rd_data_ff};
      diff    = {key_ff[VW-1], key_ff} - diff;
      mid_s   = SW'(mid_ff);
      go_left = asc_ff ? (key_ff < rd_data_ff) : (key_ff > rd_data_ff);
      nfirst  = go_left ? first_ff : (mid_s + SW'(1));
      nlast   = go_left ? (mid_s - SW'(1)) : last_ff;
      nsum    = {1'b0, nfirst} + {1'b0, nlast};

      case (state_ff)
         stvis_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.operation == stvis_pkg::OP_WRITE) begin
                  wr_en = pos_ok;
               end else begin
                  key_in       = req_bus.item_value;
                  cnt_in       = used_cnt;
                  asc_in       = (range_mode_ff == stvis_pkg::MODE_ASCEND);
                  res_found_in = 1'b0;
                  res_index_in = '0;
                  if (req_bus.item_value == invalid_marker_ff || used_cnt == '0) begin
                     state_in = stvis_pkg::ST_FINISH;
                  end else if (range_mode_ff == stvis_pkg::MODE_OFFSET) begin
                     rd_addr  = '0;
                     state_in = stvis_pkg::ST_OFFSET;
                  end else if (used_cnt < CW'(stvis_pkg::LINEAR_LIMIT)) begin
                     mid_in   = '0;
                     rd_addr  = '0;
                     state_in = stvis_pkg::ST_LINEAR;
                  end else begin
                     first_in = '0;
                     last_in  = SW'(used_cnt) - SW'(1);
                     mid_in   = AW'(used_cnt >> 1);
                     rd_addr  = AW'(used_cnt >> 1);
                     state_in = stvis_pkg::ST_BINARY;
                  end
               end
            end
         end
         stvis_pkg::ST_OFFSET: begin
            if (!diff[VW] && (diff[VW-1:0] < VW'(cnt_ff))) begin
               res_found_in = 1'b1;
               res_index_in = diff[PW-1:0];
            end
            state_in = stvis_pkg::ST_FINISH;
         end
         stvis_pkg::ST_LINEAR: begin
            if (rd_data_ff == key_ff) begin
               res_found_in = 1'b1;
               res_index_in = PW'(mid_ff);
               state_in     = stvis_pkg::ST_FINISH;
            end else if (CW'(mid_ff) + CW'(1) >= cnt_ff) begin
               state_in = stvis_pkg::ST_FINISH;
            end else begin
               mid_in  = mid_ff + AW'(1);
               rd_addr = mid_ff + AW'(1);
            end
         end
         stvis_pkg::ST_BINARY: begin
            if (rd_data_ff == key_ff) begin
               res_found_in = 1'b1;
               res_index_in = PW'(mid_ff);
               state_in     = stvis_pkg::ST_FINISH;
            end else if (nfirst > nlast) begin
               state_in = stvis_pkg::ST_FINISH;
            end else begin
               first_in = nfirst;
               last_in  = nlast;
               mid_in   = AW'(nsum >> 1);
               rd_addr  = AW'(nsum >> 1);
            end
         end
         stvis_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = stvis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stvis_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stvis_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      asc_ff       <= asc_in;
      cnt_ff       <= cnt_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      mid_ff       <= mid_in;
      res_found_ff <= res_found_in;
      res_index_ff <= res_index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_index_ff <= res_index_ff;
      end
   end

   assign req_bus.ready       = (state_ff == stvis_pkg::ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.match_index = rsp_index_ff;

   a_marker_not_found: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.operation == stvis_pkg::OP_SEARCH &&
       req_bus.item_value == invalid_marker_ff)
      |=> (state_ff == stvis_pkg::ST_FINISH && !res_found_ff))
      else $error("invalid marker search did not finish as not found");

   a_binary_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stvis_pkg::ST_BINARY)
      |-> (first_ff <= last_ff && CW'(mid_ff) < cnt_ff))
      else $error("binary search probe outside its bounds");

   a_found_in_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (CW'(rsp_index_ff) < used_cnt))
      else $error("match index beyond item count");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_index_ff == '0))
      else $error("not found beat with nonzero index");

endmodule
